/* rtl/core/jsm_pkg.sv */
// Shared types and constants for the Julia set membership block.
`timescale 1ns / 1ps

package jsm_pkg;

   localparam int IMG_WIDTH_DEF  = 1024;
   localparam int IMG_HEIGHT_DEF = 512;

   localparam int FRAC_BITS = 28;
   localparam int COL_W     = 10;
   localparam int ROW_W     = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   localparam logic [63:0] ESCAPE_MAG = 64'd4 << (2 * FRAC_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_X      = 3'd0,
      CSR_MAX_X      = 3'd1,
      CSR_MIN_Y      = 3'd2,
      CSR_MAX_Y      = 3'd3,
      CSR_C_RE       = 3'd4,
      CSR_C_IM       = 3'd5,
      CSR_ITER_COUNT = 3'd6,
      CSR_RADIUS     = 3'd7
   } csr_index_type;

   localparam logic [31:0] MIN_X_RST  = 32'hE800_0000;
   localparam logic [31:0] MAX_X_RST  = 32'h1800_0000;
   localparam logic [31:0] MIN_Y_RST  = 32'hE800_0000;
   localparam logic [31:0] MAX_Y_RST  = 32'h1800_0000;
   localparam logic [30:0] C_RE_RST   = 31'h7C6E_978D;
   localparam logic [30:0] C_IM_RST   = 31'h0BEB_851F;
   localparam logic [7:0]  ITER_RST   = 8'd50;
   localparam logic [29:0] RADIUS_RST = 30'h1000_0000;

   typedef struct packed {
      logic [31:0] min_x;
      logic [31:0] max_x;
      logic [31:0] min_y;
      logic [31:0] max_y;
      logic [30:0] c_re;
      logic [30:0] c_im;
      logic [7:0]  iteration_count;
      logic [29:0] radius;
   } cfg_type;

   typedef struct packed {
      logic load_pix;
      logic do_map;
      logic do_init;
      logic do_mul;
      logic do_step;
      logic do_finish;
   } cmd_type;

   typedef struct packed {
      logic esc;
      logic cnt_zero;
   } sts_type;

   function automatic logic [31:0] sat32(input logic signed [43:0] v);
      logic [31:0] r;
      if (v > 44'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -44'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/jsm_regs.sv */
// Configuration register file for the Julia set membership block.
`timescale 1ns / 1ps

module jsm_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [jsm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [jsm_pkg::CSR_DAT_W-1:0]     csr_wdata,
   output jsm_pkg::cfg_type                  cfg
);

   jsm_pkg::cfg_type cfg_ff;
   jsm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (jsm_pkg::csr_index_type'(csr_index))
            jsm_pkg::CSR_MIN_X:      cfg_in.min_x = csr_wdata;
            jsm_pkg::CSR_MAX_X:      cfg_in.max_x = csr_wdata;
            jsm_pkg::CSR_MIN_Y:      cfg_in.min_y = csr_wdata;
            jsm_pkg::CSR_MAX_Y:      cfg_in.max_y = csr_wdata;
            jsm_pkg::CSR_C_RE:       cfg_in.c_re = csr_wdata[30:0];
            jsm_pkg::CSR_C_IM:       cfg_in.c_im = csr_wdata[30:0];
            jsm_pkg::CSR_ITER_COUNT: cfg_in.iteration_count = csr_wdata[7:0];
            jsm_pkg::CSR_RADIUS:     cfg_in.radius = csr_wdata[29:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_x           <= jsm_pkg::MIN_X_RST;
         cfg_ff.max_x           <= jsm_pkg::MAX_X_RST;
         cfg_ff.min_y           <= jsm_pkg::MIN_Y_RST;
         cfg_ff.max_y           <= jsm_pkg::MAX_Y_RST;
         cfg_ff.c_re            <= jsm_pkg::C_RE_RST;
         cfg_ff.c_im            <= jsm_pkg::C_IM_RST;
         cfg_ff.iteration_count <= jsm_pkg::ITER_RST;
         cfg_ff.radius          <= jsm_pkg::RADIUS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/jsm_datapath.sv */
// Datapath: coordinate mapping, complex square-and-add iteration and result register.
`timescale 1ns / 1ps

module jsm_datapath #(
   parameter int IMG_WIDTH  = jsm_pkg::IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT = jsm_pkg::IMG_HEIGHT_DEF
) (
   input  logic                          clock,
   input  jsm_pkg::cmd_type              cmd,
   input  jsm_pkg::cfg_type              cfg,
   input  logic [jsm_pkg::COL_W-1:0]     req_column,
   input  logic [jsm_pkg::ROW_W-1:0]     req_row,
   output jsm_pkg::sts_type              sts,
   output logic                          rsp_in_set,
   output logic [jsm_pkg::COL_W-1:0]     rsp_out_column,
   output logic [jsm_pkg::ROW_W-1:0]     rsp_out_row
);

   localparam int XSH  = $clog2(IMG_WIDTH);
   localparam int YSH  = $clog2(IMG_HEIGHT);
   localparam int FRAC = jsm_pkg::FRAC_BITS;

   logic [jsm_pkg::COL_W-1:0] col_ff;
   logic [jsm_pkg::ROW_W-1:0] row_ff;
   logic [jsm_pkg::COL_W-1:0] out_col_ff;
   logic [jsm_pkg::ROW_W-1:0] out_row_ff;
   logic                      in_set_ff;

   logic signed [32:0] dx;
   logic signed [32:0] dy;
   logic signed [43:0] px_in;
   logic signed [43:0] py_in;
   logic signed [43:0] px_ff;
   logic signed [43:0] py_ff;
   logic        [59:0] r2_in;
   logic        [59:0] r2_ff;
   logic signed [43:0] xs;
   logic signed [43:0] ys;

   logic signed [31:0] zr_ff;
   logic signed [31:0] zi_ff;
   logic signed [31:0] zr_in;
   logic signed [31:0] zi_in;
   logic        [7:0]  cnt_ff;
   logic        [7:0]  cnt_in;

   logic signed [63:0] prr_in;
   logic signed [63:0] pii_in;
   logic signed [63:0] pri_in;
   logic signed [63:0] prr_ff;
   logic signed [63:0] pii_ff;
   logic signed [63:0] pri_ff;

   logic signed [63:0] dsq;
   logic signed [63:0] nr_w;
   logic signed [63:0] ni_w;
   logic        [63:0] mag;
   logic               esc;

   assign dx = $signed({cfg.max_x[31], cfg.max_x}) - $signed({cfg.min_x[31], cfg.min_x});
   assign dy = $signed({cfg.max_y[31], cfg.max_y}) - $signed({cfg.min_y[31], cfg.min_y});

   assign px_in = $signed({1'b0, col_ff}) * dx;
   assign py_in = $signed({1'b0, row_ff}) * dy;
   assign r2_in = 60'(cfg.radius) * 60'(cfg.radius);

   assign xs = (px_ff >>> XSH) + $signed({{12{cfg.min_x[31]}}, cfg.min_x});
   assign ys = (py_ff >>> YSH) + $signed({{12{cfg.min_y[31]}}, cfg.min_y});

   assign prr_in = zr_ff * zr_ff;
   assign pii_in = zi_ff * zi_ff;
   assign pri_in = zr_ff * zi_ff;

   assign dsq  = prr_ff - pii_ff;
   assign nr_w = (dsq >>> FRAC) + $signed({{33{cfg.c_re[30]}}, cfg.c_re});
   assign ni_w = (pri_ff >>> (FRAC - 1)) + $signed({{33{cfg.c_im[30]}}, cfg.c_im});

   assign mag = {1'b0, prr_ff[62:0]} + {1'b0, pii_ff[62:0]};
   assign esc = mag > jsm_pkg::ESCAPE_MAG;

   always_comb begin
      zr_in  = zr_ff;
      zi_in  = zi_ff;
      cnt_in = cnt_ff;
      if (cmd.do_init) begin
         zr_in  = jsm_pkg::sat32(xs);
         zi_in  = jsm_pkg::sat32(ys);
         cnt_in = cfg.iteration_count;
      end else if (cmd.do_step) begin
         zr_in  = nr_w[31:0];
         zi_in  = ni_w[31:0];
         cnt_in = cnt_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pix) begin
         col_ff <= req_column;
         row_ff <= req_row;
      end
      if (cmd.do_map) begin
         px_ff <= px_in;
         py_ff <= py_in;
         r2_ff <= r2_in;
      end
      zr_ff  <= zr_in;
      zi_ff  <= zi_in;
      cnt_ff <= cnt_in;
      if (cmd.do_mul) begin
         prr_ff <= prr_in;
         pii_ff <= pii_in;
         pri_ff <= pri_in;
      end
      if (cmd.do_finish) begin
         in_set_ff  <= !esc && (mag < {4'b0, r2_ff});
         out_col_ff <= col_ff;
         out_row_ff <= row_ff;
      end
   end

   assign sts.esc      = esc;
   assign sts.cnt_zero = (cnt_ff == 8'd0);

   assign rsp_in_set     = in_set_ff;
   assign rsp_out_column = out_col_ff;
   assign rsp_out_row    = out_row_ff;

endmodule

/* rtl/core/jsm_ctrl.sv */
// Controller state machine sequencing mapping and iteration for one pixel at a time.
`timescale 1ns / 1ps

module jsm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  jsm_pkg::sts_type  sts,
   output jsm_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_INIT,
      ST_MUL,
      ST_CHK
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;
   logic      done;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign done      = sts.esc || sts.cnt_zero;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_pix = 1'b1;
               state_in     = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.do_map = 1'b1;
            state_in   = ST_INIT;
         end
         ST_INIT: begin
            cmd.do_init = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = ST_CHK;
         end
         ST_CHK: begin
            if (!done) begin
               cmd.do_step = 1'b1;
               state_in    = ST_MUL;
            end else if (slot_free) begin
               cmd.do_finish = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.do_finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_finish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.do_finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written over an unread beat");

   a_step_only_live: assert property (@(posedge clock) disable iff (reset)
      cmd.do_step |-> (!sts.esc && !sts.cnt_zero))
      else $error("iteration after escape or count end");

   a_accept_starts_map: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MAP && !req_ready))
      else $error("accepted beat did not start mapping");

   a_finish_raises_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.do_finish |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("finished pixel not presented");
`endif

endmodule

/* rtl/core/julia_set_membership.sv */
// Top level of the Julia set membership block.
`timescale 1ns / 1ps

// Julia set escape test for one pixel per request beat.
// Request channel (req_valid/req_ready): pixel column and row. The pixel is
// mapped into the window held in the csr_ registers, then z = z*z + c runs
// for iteration_count steps in signed Q4.28, stopping early once |z|^2
// exceeds 4.0. Response channel (rsp_valid/rsp_ready): in_set plus the
// pixel's column and row.
// Each iteration runs through ST_MUL, with the three 32x32 multipliers, and
// then ST_CHK, with the add, shift and escape compare. A pixel passes from
// accept through ST_MAP and ST_INIT, then the iterations actually done (at
// most iteration_count, plus the closing magnitude check), and back to idle;
// the result beat is registered as the pixel leaves ST_CHK.
// One pixel is in flight at a time; the next request is taken while the
// previous result still waits in the output register. If that result is not
// taken when the next pixel finishes, the block holds the finished pixel.
// Reset (synchronous, active high) loads the default window and constant and
// empties both channels. Write csr_ registers only while the block is idle.
module julia_set_membership #(
   parameter int IMG_WIDTH  = jsm_pkg::IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT = jsm_pkg::IMG_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [jsm_pkg::COL_W-1:0]     req_column,
   input  logic [jsm_pkg::ROW_W-1:0]     req_row,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_in_set,
   output logic [jsm_pkg::COL_W-1:0]     rsp_out_column,
   output logic [jsm_pkg::ROW_W-1:0]     rsp_out_row,
   input  logic                          csr_we,
   input  logic [jsm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [jsm_pkg::CSR_DAT_W-1:0] csr_wdata
);

   jsm_pkg::cfg_type cfg;
   jsm_pkg::cmd_type cmd;
   jsm_pkg::sts_type sts;

   jsm_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   jsm_datapath #(
      .IMG_WIDTH  (IMG_WIDTH),
      .IMG_HEIGHT (IMG_HEIGHT)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .cfg            (cfg),
      .req_column     (req_column),
      .req_row        (req_row),
      .sts            (sts),
      .rsp_in_set     (rsp_in_set),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row)
   );

endmodule
